[src/edge_interval_refine_store_unit_defines.svh]
// assertion macros shared by the edge interval store modules
`ifndef EDGE_INTERVAL_REFINE_STORE_UNIT_DEFINES_SVH
`define EDGE_INTERVAL_REFINE_STORE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define EIRS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define EIRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/eirs_pkg.sv]
// shared types and constants of the edge interval store
`timescale 1ns / 1ps

package eirs_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_BOUND_BITS   = 32;

  localparam int VERTEX_W   = 6;
  localparam int WEIGHT_W   = 32;
  localparam int VCOUNT_W   = 7;
  localparam int COUNT_W    = 11;
  localparam int STATUS_W   = 3;
  localparam int KIND_W     = 2;
  localparam int S_TDATA_W  = 80;
  localparam int S_TUSER_W  = 3;
  localparam int M_TDATA_W  = 96;
  localparam int M_TUSER_W  = 2;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

  // register index, taken from paddr[2]
  localparam logic REG_VERTEX_COUNT = 1'b0;

  localparam logic CMD_REFINE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_UNDEF    = 2'd0,
    KIND_EXACT    = 2'd1,
    KIND_INTERVAL = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_EXACT_KEPT  = 3'd1,
    STAT_IGNORED     = 3'd2,
    STAT_UNDEF_WEIGHT = 3'd3,
    STAT_EMPTY       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_t;

  typedef struct packed {
    logic clr_en;
    logic take;
    logic exec;
  } ctl_cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic clr_last;
    logic in_valid;
    logic out_free;
  } ctl_stat_t;

endpackage

[src/edge_interval_refine_store_unit.sv]
// Symmetric vertex-pair edge table with exact and interval weights.
// Input channel s_*: one item is a refine or a read of one vertex pair.
// Output channel m_*: one result item per input item with the status, the
// entry after the step and the running exact and interval edge counts.
// Configuration: APB register 0 (byte address 0) is vertex_count; a write
// clears the table and both counts.
// Each item is a read-modify-write of its entry: the accept edge reads the pair's
// entry from the synchronous table memories, then the execute step computes the
// refinement, writes the entry back and loads the output register. A new item
// is taken only after that execute step, so the block does not take an item before
// it is through with the last one; this is set by the read-modify-write of the entry.
// While a result waits in the output register the execute step holds, and
// the input side stalls until m_tready frees the register.
// After reset, and after each vertex_count write, a clearing pass marks
// every one of the (2**clog2(MAX_VERTICES))**2 entries undefined, one entry a
// cycle, 4096 entries at the default size; no item is accepted meanwhile.
`timescale 1ns / 1ps

module edge_interval_refine_store_unit #(
  parameter int MAX_VERTICES = eirs_pkg::DEF_MAX_VERTICES,
  parameter int BOUND_BITS   = eirs_pkg::DEF_BOUND_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  // input item
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // vertex_a[5:0], vertex_b[11:6], weight_low[43:12], weight_high[75:44], zero pad
  input  logic [eirs_pkg::S_TDATA_W-1:0]  s_tdata,
  // command[0], weight_kind[2:1]
  input  logic [eirs_pkg::S_TUSER_W-1:0]  s_tuser,
  // result item
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status[2:0], edge_low[34:3], edge_high[66:35], exact_count[77:67],
  // interval_count[88:78], zero pad
  output logic [eirs_pkg::M_TDATA_W-1:0]  m_tdata,
  // edge_kind[1:0]
  output logic [eirs_pkg::M_TUSER_W-1:0]  m_tuser,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [eirs_pkg::PADDR_W-1:0]    paddr,
  input  logic [eirs_pkg::PDATA_W-1:0]    pwdata,
  output logic [eirs_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  eirs_pkg::ctl_cmd_t  cmd;
  eirs_pkg::ctl_stat_t stat;

  assign pready   = 1'b1;
  assign s_tready = cmd.take;

  eirs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  eirs_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .BOUND_BITS   (BOUND_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
  );

endmodule

[src/eirs_ram.sv]
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module eirs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/eirs_ctrl.sv]
// controller: clearing sweep, item accept and execute sequencing
`timescale 1ns / 1ps
`include "edge_interval_refine_store_unit_defines.svh"

module eirs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  eirs_pkg::ctl_stat_t stat,
  output eirs_pkg::ctl_cmd_t  cmd
);

  eirs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eirs_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      eirs_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_next = eirs_pkg::ST_IDLE;
      end
      eirs_pkg::ST_IDLE: begin
        if (stat.in_valid) state_next = eirs_pkg::ST_EXEC;
      end
      eirs_pkg::ST_EXEC: begin
        if (stat.out_free) state_next = eirs_pkg::ST_IDLE;
      end
      default: state_next = eirs_pkg::ST_CLEAR;
    endcase
    // a register write wipes the table again
    if (stat.cfg_wr) state_next = eirs_pkg::ST_CLEAR;
  end

  always_comb begin
    cmd = '0;
    case (state)
      eirs_pkg::ST_CLEAR: cmd.clr_en = 1'b1;
      eirs_pkg::ST_IDLE:  cmd.take   = 1'b1;
      eirs_pkg::ST_EXEC:  cmd.exec   = stat.out_free;
      default:            cmd        = '0;
    endcase
  end

  `EIRS_ASSERT(a_exec_slot_free, cmd.exec, stat.out_free, "execute with output slot busy")
  `EIRS_ASSERT(a_clear_blocks_take, state == eirs_pkg::ST_CLEAR, !cmd.take && !cmd.exec, "item taken during clear")
  `EIRS_ASSERT_NEXT(a_accept_to_exec, (state == eirs_pkg::ST_IDLE) && stat.in_valid && !stat.cfg_wr, state == eirs_pkg::ST_EXEC, "accepted item not executed")

endmodule

[src/eirs_datapath.sv]
// datapath: edge tables, refine logic, running counts, register and output
`timescale 1ns / 1ps
`include "edge_interval_refine_store_unit_defines.svh"

module eirs_datapath #(
  parameter int MAX_VERTICES = eirs_pkg::DEF_MAX_VERTICES,
  parameter int BOUND_BITS   = eirs_pkg::DEF_BOUND_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  eirs_pkg::ctl_cmd_t                cmd,
  output eirs_pkg::ctl_stat_t               stat,
  input  logic                              s_tvalid,
  input  logic [eirs_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic [eirs_pkg::S_TUSER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [eirs_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic [eirs_pkg::M_TUSER_W-1:0]    m_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [eirs_pkg::PADDR_W-1:0]      paddr,
  input  logic [eirs_pkg::PDATA_W-1:0]      pwdata,
  output logic [eirs_pkg::PDATA_W-1:0]      prdata
);

  localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int AW    = 2 * VW;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = eirs_pkg::COUNT_W;
  localparam int NCAP_INT = (MAX_VERTICES < 127) ? MAX_VERTICES : 127;
  localparam logic [eirs_pkg::VCOUNT_W-1:0] N_CAP = eirs_pkg::VCOUNT_W'(NCAP_INT);

  // ---------------- configuration register ----------------
  logic [eirs_pkg::VCOUNT_W-1:0] vertex_count;
  logic                          cfg_wr;
  logic [eirs_pkg::VCOUNT_W-1:0] n_eff;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == eirs_pkg::REG_VERTEX_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= eirs_pkg::VCOUNT_RESET;
    end else if (cfg_wr) begin
      vertex_count <= pwdata[eirs_pkg::VCOUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == eirs_pkg::REG_VERTEX_COUNT) ?
                  eirs_pkg::PDATA_W'(vertex_count) : '0;
  assign n_eff  = (vertex_count > N_CAP) ? N_CAP : vertex_count;

  // ---------------- clearing sweep counter ----------------
  logic [AW-1:0] clr_cnt;
  logic          clr_last;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign clr_last = cmd.clr_en && (clr_cnt == {AW{1'b1}});

  // ---------------- input decode ----------------
  logic                              accept;
  logic [eirs_pkg::VERTEX_W-1:0]     in_a, in_b, v_lo, v_hi;
  logic [AW-1:0]                     in_addr;
  logic                              in_ignore;
  logic [eirs_pkg::WEIGHT_W-1:0]     in_wl_raw, in_wh_raw;
  logic signed [BOUND_BITS-1:0]      in_wl, in_wh;

  assign accept    = cmd.take && s_tvalid;
  assign in_a      = s_tdata[5:0];
  assign in_b      = s_tdata[11:6];
  assign in_wl_raw = s_tdata[43:12];
  assign in_wh_raw = s_tdata[75:44];
  assign v_lo      = (in_a < in_b) ? in_a : in_b;
  assign v_hi      = (in_a < in_b) ? in_b : in_a;
  // only the upper triangle is stored, the table is symmetric
  assign in_addr   = {VW'(v_lo), VW'(v_hi)};
  assign in_ignore = (in_a == in_b) || ({1'b0, in_a} >= n_eff) || ({1'b0, in_b} >= n_eff);

  generate
    if (BOUND_BITS <= eirs_pkg::WEIGHT_W) begin : g_bound_narrow
      assign in_wl = in_wl_raw[BOUND_BITS-1:0];
      assign in_wh = in_wh_raw[BOUND_BITS-1:0];
    end else begin : g_bound_wide
      assign in_wl = BOUND_BITS'(signed'(in_wl_raw));
      assign in_wh = BOUND_BITS'(signed'(in_wh_raw));
    end
  endgenerate

  // item register
  logic                         item_cmd;
  logic                         item_ignore;
  logic [AW-1:0]                item_addr;
  logic [1:0]                   item_wk;
  logic signed [BOUND_BITS-1:0] item_wl, item_wh;

  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd    <= s_tuser[0];
      item_wk     <= s_tuser[2:1];
      item_ignore <= in_ignore;
      item_addr   <= in_addr;
      item_wl     <= in_wl;
      item_wh     <= in_wh;
    end
  end

  // ---------------- tables ----------------
  logic                         wr_en;
  logic                         kind_we;
  logic [AW-1:0]                kind_waddr;
  logic [eirs_pkg::KIND_W-1:0]  kind_wdata, kind_rdata;
  logic [2*BOUND_BITS-1:0]      bnd_rdata;
  eirs_pkg::kind_t              cur_kind, new_kind;
  logic signed [BOUND_BITS-1:0] cur_lo, cur_hi, new_lo, new_hi, nl, nu;

  assign kind_we    = cmd.clr_en || (cmd.exec && wr_en);
  assign kind_waddr = cmd.clr_en ? clr_cnt : item_addr;
  assign kind_wdata = cmd.clr_en ? eirs_pkg::KIND_UNDEF : new_kind;

  eirs_ram #(
    .WIDTH (eirs_pkg::KIND_W),
    .DEPTH (DEPTH)
  ) u_kind_ram (
    .clk   (clk),
    .we    (kind_we),
    .waddr (kind_waddr),
    .wdata (kind_wdata),
    .re    (accept),
    .raddr (in_addr),
    .rdata (kind_rdata)
  );

  eirs_ram #(
    .WIDTH (2 * BOUND_BITS),
    .DEPTH (DEPTH)
  ) u_bound_ram (
    .clk   (clk),
    .we    (cmd.exec && wr_en),
    .waddr (item_addr),
    .wdata ({new_hi, new_lo}),
    .re    (accept),
    .raddr (in_addr),
    .rdata (bnd_rdata)
  );

  assign cur_kind = eirs_pkg::kind_t'(kind_rdata);
  assign cur_lo   = bnd_rdata[BOUND_BITS-1:0];
  assign cur_hi   = bnd_rdata[2*BOUND_BITS-1:BOUND_BITS];
  assign nl       = (item_wl > cur_lo) ? item_wl : cur_lo;
  assign nu       = (item_wh < cur_hi) ? item_wh : cur_hi;

  // ---------------- refine decision ----------------
  eirs_pkg::status_t            res_status;
  eirs_pkg::kind_t              res_kind;
  logic signed [BOUND_BITS-1:0] res_lo, res_hi;

  always_comb begin
    wr_en      = 1'b0;
    new_kind   = cur_kind;
    new_lo     = cur_lo;
    new_hi     = cur_hi;
    res_status = eirs_pkg::STAT_OK;
    if (item_ignore) begin
      res_status = eirs_pkg::STAT_IGNORED;
    end else if (item_cmd == eirs_pkg::CMD_REFINE) begin
      if (cur_kind == eirs_pkg::KIND_EXACT) begin
        res_status = eirs_pkg::STAT_EXACT_KEPT;
      end else begin
        case (eirs_pkg::kind_t'(item_wk))
          eirs_pkg::KIND_EXACT: begin
            wr_en    = 1'b1;
            new_kind = eirs_pkg::KIND_EXACT;
            new_lo   = item_wl;
            new_hi   = item_wl;
          end
          eirs_pkg::KIND_INTERVAL: begin
            if (cur_kind == eirs_pkg::KIND_INTERVAL) begin
              if (nl > nu) begin
                res_status = eirs_pkg::STAT_EMPTY;
              end else begin
                wr_en  = 1'b1;
                new_lo = nl;
                new_hi = nu;
              end
            end else begin
              wr_en    = 1'b1;
              new_kind = eirs_pkg::KIND_INTERVAL;
              new_lo   = item_wl;
              new_hi   = item_wh;
            end
          end
          default: res_status = eirs_pkg::STAT_UNDEF_WEIGHT;
        endcase
      end
    end
    res_kind = item_ignore ? eirs_pkg::KIND_UNDEF : new_kind;
    if (item_ignore || (new_kind == eirs_pkg::KIND_UNDEF)) begin
      res_lo = '0;
      res_hi = '0;
    end else begin
      res_lo = new_lo;
      res_hi = new_hi;
    end
  end

  // ---------------- running counts ----------------
  logic [CW-1:0] exact_count, interval_count;
  logic [CW-1:0] exact_next, interval_next;

  always_comb begin
    exact_next    = exact_count;
    interval_next = interval_count;
    if (cmd.exec && wr_en) begin
      exact_next = exact_count - CW'(cur_kind == eirs_pkg::KIND_EXACT)
                               + CW'(new_kind == eirs_pkg::KIND_EXACT);
      interval_next = interval_count - CW'(cur_kind == eirs_pkg::KIND_INTERVAL)
                                     + CW'(new_kind == eirs_pkg::KIND_INTERVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      exact_count    <= '0;
      interval_count <= '0;
    end else begin
      exact_count    <= exact_next;
      interval_count <= interval_next;
    end
  end

  // ---------------- result register ----------------
  logic [eirs_pkg::WEIGHT_W-1:0] out_lo, out_hi;

  generate
    if (BOUND_BITS >= eirs_pkg::WEIGHT_W) begin : g_out_wide
      assign out_lo = res_lo[eirs_pkg::WEIGHT_W-1:0];
      assign out_hi = res_hi[eirs_pkg::WEIGHT_W-1:0];
    end else begin : g_out_narrow
      assign out_lo = eirs_pkg::WEIGHT_W'(res_lo);
      assign out_hi = eirs_pkg::WEIGHT_W'(res_hi);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      m_tdata <= {7'd0, interval_next, exact_next, out_hi, out_lo, res_status};
      m_tuser <= res_kind;
    end
  end

  assign stat.cfg_wr   = cfg_wr;
  assign stat.clr_last = clr_last;
  assign stat.in_valid = s_tvalid;
  assign stat.out_free = !m_tvalid || m_tready;

  `EIRS_ASSERT(a_no_write_ignored, cmd.exec && item_ignore, !wr_en, "ignored pair written")
  `EIRS_ASSERT(a_valid_from_exec, $rose(m_tvalid), $past(cmd.exec), "result without execute")
  `EIRS_ASSERT_NEXT(a_count_step, !cfg_wr, (exact_count == $past(exact_count)) || (exact_count == $past(exact_count) + CW'(1)) || (exact_count == $past(exact_count) - CW'(1)), "exact count jumped")

endmodule

[tb/tb_edge_interval_refine_store_unit.sv]
// self-checking testbench for the edge interval refine store unit
`timescale 1ns / 1ps

module tb_edge_interval_refine_store_unit;
  import eirs_pkg::*;

  localparam int TABLE_SIDE = DEF_MAX_VERTICES;
  localparam int QUIET_LIMIT = 20000;
  localparam int PRESSURE_CYCLES = 300;
  localparam int CALM_TAIL = 150;
  localparam logic [KIND_W-1:0] WEIGHT_KIND_SPARE = 2'd3;

  typedef struct packed {
    logic                cmd;
    logic [VERTEX_W-1:0] va;
    logic [VERTEX_W-1:0] vb;
    logic [KIND_W-1:0]   wk;
    logic [31:0]         wl;
    logic [31:0]         wh;
  } edge_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KIND_W-1:0]   kind;
    logic [31:0]         lo;
    logic [31:0]         hi;
    logic [COUNT_W-1:0]  exact_n;
    logic [COUNT_W-1:0]  interval_n;
  } edge_res_t;

  typedef struct packed {
    edge_req_t req;
    logic      typed;
    edge_res_t res;
  } edge_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // vertex_a[5:0], vertex_b[11:6], weight_low[43:12], weight_high[75:44], zero pad
  logic [S_TDATA_W-1:0] s_tdata = '0;
  // command[0], weight_kind[2:1]
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // status[2:0], edge_low[34:3], edge_high[66:35], exact_count[77:67],
  // interval_count[88:78], zero pad
  logic [M_TDATA_W-1:0] m_tdata;
  // edge_kind[1:0]
  logic [M_TUSER_W-1:0] m_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  edge_interval_refine_store_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // edge table mirror
  logic [KIND_W-1:0] pair_kind_m  [0:TABLE_SIDE-1][0:TABLE_SIDE-1];
  logic [31:0]       pair_lo_m    [0:TABLE_SIDE-1][0:TABLE_SIDE-1];
  logic [31:0]       pair_hi_m    [0:TABLE_SIDE-1][0:TABLE_SIDE-1];
  bit                ever_written [0:TABLE_SIDE-1][0:TABLE_SIDE-1];
  int unsigned exact_total;
  int unsigned interval_total;
  int unsigned active_vertices = VCOUNT_RESET;

  edge_res_t pending_edges[$];
  edge_row_t row_notes[$];
  int bad_fields = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  bit pressure_done = 1'b0;

  function automatic void clear_edge_table();
    for (int i = 0; i < TABLE_SIDE; i++) begin
      for (int j = 0; j < TABLE_SIDE; j++) begin
        pair_kind_m[i][j] = KIND_UNDEF;
        pair_lo_m[i][j] = '0;
        pair_hi_m[i][j] = '0;
      end
    end
    exact_total = 0;
    interval_total = 0;
  endfunction

  function automatic bit pair_in_range(edge_req_t r);
    int unsigned nv;
    nv = (active_vertices > TABLE_SIDE) ? TABLE_SIDE : active_vertices;
    return (r.va != r.vb) && (r.va < nv) && (r.vb < nv);
  endfunction

  function automatic void store_pair(int a, int b, logic [KIND_W-1:0] k,
                                     logic [31:0] lo, logic [31:0] hi);
    if (pair_kind_m[a][b] == KIND_EXACT) exact_total--;
    if (pair_kind_m[a][b] == KIND_INTERVAL) interval_total--;
    if (k == KIND_EXACT) exact_total++;
    if (k == KIND_INTERVAL) interval_total++;
    pair_kind_m[a][b] = k;
    pair_kind_m[b][a] = k;
    pair_lo_m[a][b] = lo;
    pair_lo_m[b][a] = lo;
    pair_hi_m[a][b] = hi;
    pair_hi_m[b][a] = hi;
  endfunction

  function automatic edge_res_t refine_edge(edge_req_t r);
    edge_res_t res;
    int a;
    int b;
    logic [KIND_W-1:0] cur;
    logic [31:0] nl;
    logic [31:0] nu;
    res = '0;
    a = r.va;
    b = r.vb;
    if (!pair_in_range(r)) begin
      res.status = STAT_IGNORED;
    end else begin
      res.status = STAT_OK;
      cur = pair_kind_m[a][b];
      if (r.cmd == CMD_REFINE) begin
        if (cur == KIND_EXACT) begin
          res.status = STAT_EXACT_KEPT;
        end else if (r.wk == KIND_EXACT) begin
          store_pair(a, b, KIND_EXACT, r.wl, r.wl);
        end else if (r.wk == KIND_INTERVAL) begin
          if (cur == KIND_INTERVAL) begin
            nl = ($signed(r.wl) > $signed(pair_lo_m[a][b])) ? r.wl : pair_lo_m[a][b];
            nu = ($signed(r.wh) < $signed(pair_hi_m[a][b])) ? r.wh : pair_hi_m[a][b];
            if ($signed(nl) > $signed(nu)) res.status = STAT_EMPTY;
            else store_pair(a, b, KIND_INTERVAL, nl, nu);
          end else begin
            store_pair(a, b, KIND_INTERVAL, r.wl, r.wh);
          end
        end else begin
          res.status = STAT_UNDEF_WEIGHT;
        end
      end
      res.kind = pair_kind_m[a][b];
      if (res.kind != KIND_UNDEF) begin
        res.lo = pair_lo_m[a][b];
        res.hi = pair_hi_m[a][b];
      end
    end
    res.exact_n = exact_total[COUNT_W-1:0];
    res.interval_n = interval_total[COUNT_W-1:0];
    return res;
  endfunction

  function automatic edge_req_t mk_req(logic cmd, int va, int vb, logic [KIND_W-1:0] wk,
                                       logic [31:0] wl, logic [31:0] wh);
    edge_req_t r;
    r.cmd = cmd;
    r.va = va;
    r.vb = vb;
    r.wk = wk;
    r.wl = wl;
    r.wh = wh;
    return r;
  endfunction

  function automatic edge_res_t mk_res(logic [STATUS_W-1:0] status, logic [KIND_W-1:0] kind,
                                       logic [31:0] lo, logic [31:0] hi, int ne, int ni);
    edge_res_t r;
    r.status = status;
    r.kind = kind;
    r.lo = lo;
    r.hi = hi;
    r.exact_n = ne;
    r.interval_n = ni;
    return r;
  endfunction

  // a refine with a real weight on a valid pair always leaves the entry written
  function automatic void note_write(edge_req_t r);
    if (r.cmd == CMD_REFINE && (r.wk == KIND_EXACT || r.wk == KIND_INTERVAL) &&
        pair_in_range(r)) begin
      ever_written[r.va][r.vb] = 1'b1;
      ever_written[r.vb][r.va] = 1'b1;
    end
  endfunction

  function automatic edge_req_t random_edge_item();
    edge_req_t r;
    int nv;
    int hot;
    int pick;
    int lo_i;
    int span;
    nv = (active_vertices > TABLE_SIDE) ? TABLE_SIDE : active_vertices;
    hot = (nv < 6) ? nv : 6;
    r.cmd = ($urandom_range(0, 99) < 15) ? CMD_READ : CMD_REFINE;
    if (nv >= 2 && $urandom_range(0, 9) != 0) begin
      // mostly a few hot vertices so refinements of one pair pile up
      if ($urandom_range(0, 2) != 0) begin
        r.va = $urandom_range(0, hot - 1);
        r.vb = $urandom_range(0, hot - 1);
      end else begin
        r.va = $urandom_range(0, nv - 1);
        r.vb = $urandom_range(0, nv - 1);
      end
    end else begin
      r.va = $urandom;
      r.vb = $urandom;
    end
    pick = $urandom_range(0, 99);
    if (pick < 4) r.wk = KIND_UNDEF;
    else if (pick < 8) r.wk = WEIGHT_KIND_SPARE;
    else if (pick < 18) r.wk = KIND_EXACT;
    else r.wk = KIND_INTERVAL;
    if ($urandom_range(0, 4) == 0) begin
      r.wl = $urandom;
      r.wh = $urandom;
    end else begin
      lo_i = int'($urandom_range(0, 400)) - 200;
      span = int'($urandom_range(0, 160)) - 10;
      r.wl = lo_i * 4096;
      r.wh = (lo_i + span) * 4096;
    end
    // bound memories of an entry never written hold no known value
    if (pair_in_range(r) && !ever_written[r.va][r.vb] &&
        (r.cmd == CMD_READ || (r.wk != KIND_EXACT && r.wk != KIND_INTERVAL))) begin
      r.cmd = CMD_REFINE;
      r.wk = KIND_INTERVAL;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      bad_fields++;
    end
  endfunction

  task automatic offer_item(edge_row_t row);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    note_write(row.req);
    row_notes.push_back(row);
    s_tdata <= {4'd0, row.req.wh, row.req.wl, row.req.vb, row.req.va};
    s_tuser <= {row.req.wk, row.req.cmd};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic offer_random(int count, bit last_phase);
    edge_row_t row;
    for (int i = 0; i < count; i++) begin
      if (last_phase && i >= count - CALM_TAIL) calm = 1'b1;
      row = '0;
      row.req = random_edge_item();
      offer_item(row);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_edges.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [VCOUNT_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_VERTEX_COUNT, 2'b00};
    pwdata <= {{(PDATA_W - VCOUNT_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    active_vertices = value;
    clear_edge_table();
  endtask

  // result side: random stalls, one long hold-off, none at the tail
  initial begin
    forever begin
      if (!calm && !pressure_done && results_seen >= 100) begin
        m_tready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    edge_req_t got_req;
    edge_res_t want;
    edge_row_t note;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        got_req.va = s_tdata[5:0];
        got_req.vb = s_tdata[11:6];
        got_req.wl = s_tdata[43:12];
        got_req.wh = s_tdata[75:44];
        got_req.cmd = s_tuser[0];
        got_req.wk = s_tuser[2:1];
        want = refine_edge(got_req);
        note = row_notes.pop_front();
        if (note.typed) want = note.res;
        pending_edges.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (pending_edges.size() == 0) begin
          $error("result item with no expectation waiting");
          bad_fields++;
        end else begin
          want = pending_edges.pop_front();
          check_field("status", want.status, m_tdata[2:0]);
          check_field("edge_kind", want.kind, m_tuser[1:0]);
          check_field("edge_low", want.lo, m_tdata[34:3]);
          check_field("edge_high", want.hi, m_tdata[66:35]);
          check_field("exact_count", want.exact_n, m_tdata[77:67]);
          check_field("interval_count", want.interval_n, m_tdata[88:78]);
        end
      end
    end
  end

  // the clearing pass after reset or a register write is the longest quiet stretch
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL edge_interval_refine_store_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    edge_row_t plan[$];
    int vcount_plan[6];
    int items_plan[6];
    vcount_plan = '{2, 127, 0, 5, 33, 64};
    items_plan = '{120, 300, 30, 220, 330, 400};
    clear_edge_table();
    for (int i = 0; i < TABLE_SIDE; i++) begin
      for (int j = 0; j < TABLE_SIDE; j++) ever_written[i][j] = 1'b0;
    end

    plan.push_back('{mk_req(CMD_REFINE, 0, 1, KIND_EXACT, 32'h7FFF_FFFF, 32'h8000_0000), 1'b1,
                     mk_res(STAT_OK, KIND_EXACT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0)});
    plan.push_back('{mk_req(CMD_READ, 1, 0, KIND_UNDEF, 32'h0, 32'h0), 1'b1,
                     mk_res(STAT_OK, KIND_EXACT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0)});
    plan.push_back('{mk_req(CMD_REFINE, 1, 0, KIND_INTERVAL, 32'h0, 32'h0001_0000), 1'b1,
                     mk_res(STAT_EXACT_KEPT, KIND_EXACT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0)});
    plan.push_back('{mk_req(CMD_REFINE, 63, 62, KIND_INTERVAL, 32'h8000_0000, 32'h7FFF_FFFF),
                     1'b1,
                     mk_res(STAT_OK, KIND_INTERVAL, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1)});
    plan.push_back('{mk_req(CMD_REFINE, 62, 63, KIND_INTERVAL, 32'hFFFB_0000, 32'h0003_0000),
                     1'b0, edge_res_t'('0)});
    plan.push_back('{mk_req(CMD_REFINE, 63, 62, KIND_INTERVAL, 32'h0004_0000, 32'h000A_0000),
                     1'b1,
                     mk_res(STAT_EMPTY, KIND_INTERVAL, 32'hFFFB_0000, 32'h0003_0000, 1, 1)});
    plan.push_back('{mk_req(CMD_REFINE, 62, 63, KIND_UNDEF, 32'h0001_0000, 32'h0002_0000),
                     1'b1,
                     mk_res(STAT_UNDEF_WEIGHT, KIND_INTERVAL, 32'hFFFB_0000, 32'h0003_0000,
                            1, 1)});
    plan.push_back('{mk_req(CMD_READ, 5, 5, KIND_INTERVAL, 32'h0, 32'h0), 1'b1,
                     mk_res(STAT_IGNORED, KIND_UNDEF, 32'h0, 32'h0, 1, 1)});
    plan.push_back('{mk_req(CMD_REFINE, 63, 62, WEIGHT_KIND_SPARE, 32'h0, 32'h0), 1'b0,
                     edge_res_t'('0)});
    // a new interval is kept even when inverted, then any intersection is empty
    plan.push_back('{mk_req(CMD_REFINE, 10, 20, KIND_INTERVAL, 32'h0007_0000, 32'hFFF9_0000),
                     1'b0, edge_res_t'('0)});
    plan.push_back('{mk_req(CMD_REFINE, 20, 10, KIND_INTERVAL, 32'hFFFF_FF9C, 32'h0000_0064),
                     1'b0, edge_res_t'('0)});
    plan.push_back('{mk_req(CMD_REFINE, 10, 20, KIND_EXACT, 32'h0, 32'hDEAD_BEEF), 1'b0,
                     edge_res_t'('0)});
    plan.push_back('{mk_req(CMD_REFINE, 30, 31, KIND_INTERVAL, 32'h8000_0000, 32'h8000_0000),
                     1'b0, edge_res_t'('0)});
    plan.push_back('{mk_req(CMD_REFINE, 31, 30, KIND_INTERVAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
                     1'b0, edge_res_t'('0)});
    plan.push_back('{mk_req(CMD_REFINE, 40, 41, KIND_EXACT, 32'h8000_0000, 32'h7FFF_FFFF),
                     1'b0, edge_res_t'('0)});
    plan.push_back('{mk_req(CMD_READ, 41, 40, KIND_EXACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0,
                     edge_res_t'('0)});
    plan.push_back('{mk_req(CMD_REFINE, 63, 0, KIND_INTERVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                     1'b0, edge_res_t'('0)});
    plan.push_back('{mk_req(CMD_REFINE, 0, 63, WEIGHT_KIND_SPARE, 32'hFFFF_FFFF, 32'h0), 1'b0,
                     edge_res_t'('0)});
    plan.push_back('{mk_req(CMD_READ, 0, 63, WEIGHT_KIND_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                     1'b0, edge_res_t'('0)});
    plan.push_back('{mk_req(CMD_REFINE, 63, 0, KIND_INTERVAL, 32'h8000_0000, 32'hFFFF_FFFF),
                     1'b0, edge_res_t'('0)});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) offer_item(plan[k]);
    offer_random(380, 1'b0);

    foreach (vcount_plan[p]) begin
      drain_results();
      write_vertex_count(vcount_plan[p]);
      offer_random(items_plan[p], p == 5);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (bad_fields == 0) begin
      $display("PASS edge_interval_refine_store_unit");
    end else begin
      $display("FAIL edge_interval_refine_store_unit");
    end
    $finish;
  end

endmodule
